// File: hw/rtl/hashed_path_table_assert.svh
// Assertion macros used by the checker file hpt_checker.sv.
`ifndef HASHED_PATH_TABLE_ASSERT_SVH
`define HASHED_PATH_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HPT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define HPT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/hpt_pkg.sv
`default_nettype none
package hpt_pkg;
  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } hpt_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOOMANY  = 2'd3
  } hpt_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_PROBE,
    BK_DECIDE,
    BK_COPY,
    BK_SEARCH,
    BK_EMIT
  } hpt_bk_state_t;

  localparam int unsigned PATH_W   = 32;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CNT_W    = 4;
  localparam logic [3:0]  FOLD_MUL = 4'd10;
endpackage
`default_nettype wire

// File: hw/rtl/hpt_ram.sv
`default_nettype none
module hpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/hpt_front.sv
`default_nettype none
// Front end: stages insert paths, hashes the key by folding its bytes and a
// reciprocal divide, and queues one command per item that needs the back end.
module hpt_front
  import hpt_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = 256,
  parameter int unsigned MAX_PATHS    = 8,
  localparam int unsigned BKT_W = $clog2(BUCKET_COUNT),
  localparam int unsigned SP_W  = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1,
  localparam int unsigned SC_W  = $clog2(MAX_PATHS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_mode,
  input  wire logic [ADDR_W-1:0] in_dest_addr,
  input  wire logic [PATH_W-1:0] in_path_id,
  input  wire logic              in_path_last,
  // command queue output
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output logic [1:0]             cmd_mode,
  output logic [ADDR_W-1:0]      cmd_addr,
  output logic [BKT_W-1:0]       cmd_bucket,
  output logic [SC_W-1:0]        cmd_count,
  output logic                   cmd_over,
  // staged path read port for the back end
  input  wire logic [SP_W-1:0]   sp_raddr,
  output logic [PATH_W-1:0]      sp_rdata,
  // back end finished with the staged set
  input  wire logic              stage_done
);
  localparam int unsigned QD = 2;
  // folded sum of four bytes stays below 2**19; bucket = sum mod BUCKET_COUNT
  // via reciprocal multiply (exact for every 19-bit sum)
  localparam int unsigned SUM_W = 19;
  localparam int unsigned RCP_W = SUM_W + 1;
  localparam int unsigned RS_W  = SUM_W + $clog2(BUCKET_COUNT);
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << RS_W) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);
  localparam logic [2:0] STEP_DONE = 3'd4;

  logic [PATH_W-1:0] stage_r [MAX_PATHS];
  logic [SC_W-1:0]   scount_r, scount_nxt;
  logic              sover_r, sover_nxt;
  logic              busy_r, busy_nxt;   // hashing or waiting for queue space
  logic              hold_r, hold_nxt;   // staged set owned by back end
  logic [2:0]        step_r, step_nxt;
  logic [1:0]        hmode_r;
  logic [ADDR_W-1:0] haddr_r;
  logic [ADDR_W-1:0] sum_r, sum_nxt;
  logic [ADDR_W+3:0] prod;
  logic [SUM_W+RCP_W-1:0] qprod;
  logic [SUM_W-1:0]  quot_r;
  logic [SUM_W-1:0]  hrem;

  // queue
  logic [1:0]        q_mode_r [QD];
  logic [ADDR_W-1:0] q_addr_r [QD];
  logic [BKT_W-1:0]  q_bkt_r  [QD];
  logic [SC_W-1:0]   q_cnt_r  [QD];
  logic              q_over_r [QD];
  logic [1:0]        q_n_r;
  logic [1:0]        q_wpos;
  logic              q_push, q_pop;
  logic              acc, needs_hash, hash_done;

  assign acc = in_valid && in_ready;
  // one item in flight through the hasher; staged set frozen while committing
  assign in_ready = !busy_r && !hold_r;
  assign needs_hash = (in_mode == MODE_SEARCH) ||
                      (in_mode == MODE_INSERT && in_path_last) ||
                      (in_mode == MODE_CLEAR);
  assign prod = {4'b0, sum_r} * {{ADDR_W{1'b0}}, FOLD_MUL};
  assign qprod = sum_r[SUM_W-1:0] * RCP;
  assign hrem = sum_r[SUM_W-1:0] - SUM_W'(quot_r * BUCKET_COUNT);
  assign hash_done = busy_r && (step_r == STEP_DONE) && (q_n_r < 2'(QD));
  assign q_push = hash_done;
  assign q_pop  = cmd_valid && cmd_ready;
  assign q_wpos = q_n_r - {1'b0, q_pop};

  always_comb begin
    scount_nxt = scount_r;
    sover_nxt  = sover_r;
    busy_nxt   = busy_r;
    hold_nxt   = hold_r;
    step_nxt   = step_r;
    sum_nxt    = sum_r;
    if (acc && in_mode == MODE_INSERT) begin
      if (scount_r < SC_W'(MAX_PATHS)) begin
        scount_nxt = scount_r + 1'b1;
      end else begin
        sover_nxt = 1'b1;
      end
    end
    if (acc && needs_hash) begin
      busy_nxt = 1'b1;
      step_nxt = 3'd0;
      sum_nxt  = {24'b0, in_dest_addr[31:24]};
    end else if (busy_r && step_r != STEP_DONE) begin
      // steps 0..2 fold the low bytes, step 3 waits for the quotient
      step_nxt = step_r + 1'b1;
      if (step_r < 3'd3) begin
        sum_nxt = prod[ADDR_W-1:0] + {24'b0, haddr_r[23 - 8*step_r[1:0] -: 8]};
      end
    end else if (hash_done) begin
      busy_nxt = 1'b0;
      if (hmode_r == MODE_INSERT) begin
        hold_nxt = 1'b1;
      end else if (hmode_r == MODE_CLEAR) begin
        scount_nxt = '0;
        sover_nxt  = 1'b0;
      end
    end
    if (stage_done) begin
      hold_nxt   = 1'b0;
      scount_nxt = '0;
      sover_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scount_r <= '0;
      sover_r  <= 1'b0;
      busy_r   <= 1'b0;
      hold_r   <= 1'b0;
      step_r   <= '0;
      q_n_r    <= '0;
    end else begin
      scount_r <= scount_nxt;
      sover_r  <= sover_nxt;
      busy_r   <= busy_nxt;
      hold_r   <= hold_nxt;
      step_r   <= step_nxt;
      case ({q_push, q_pop})
        2'b10:   q_n_r <= q_n_r + 1'b1;
        2'b01:   q_n_r <= q_n_r - 1'b1;
        default: q_n_r <= q_n_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    quot_r <= SUM_W'(qprod >> RS_W);
    if (acc) begin
      hmode_r <= in_mode;
      haddr_r <= in_dest_addr;
    end
    if (acc && in_mode == MODE_INSERT && scount_r < SC_W'(MAX_PATHS)) begin
      stage_r[scount_r[SP_W-1:0]] <= in_path_id;
    end
    if (q_pop) begin
      q_mode_r[0] <= q_mode_r[1];
      q_addr_r[0] <= q_addr_r[1];
      q_bkt_r[0]  <= q_bkt_r[1];
      q_cnt_r[0]  <= q_cnt_r[1];
      q_over_r[0] <= q_over_r[1];
    end
    if (q_push) begin
      q_mode_r[q_wpos[0]] <= hmode_r;
      q_addr_r[q_wpos[0]] <= haddr_r;
      q_bkt_r[q_wpos[0]]  <= BKT_W'(hrem);
      q_cnt_r[q_wpos[0]]  <= scount_r;
      q_over_r[q_wpos[0]] <= sover_r;
    end
  end

  assign cmd_valid  = (q_n_r != 2'd0);
  assign cmd_mode   = q_mode_r[0];
  assign cmd_addr   = q_addr_r[0];
  assign cmd_bucket = q_bkt_r[0];
  assign cmd_count  = q_cnt_r[0];
  assign cmd_over   = q_over_r[0];
  assign sp_rdata   = stage_r[sp_raddr];
endmodule
`default_nettype wire

// File: hw/rtl/hpt_back.sv
`default_nettype none
// Back end: probes the ways of a bucket, commits inserts, streams search
// results and sweeps the valid bits on clear and after reset.
module hpt_back
  import hpt_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = 256,
  parameter int unsigned WAYS         = 4,
  parameter int unsigned MAX_PATHS    = 8,
  localparam int unsigned BKT_W  = $clog2(BUCKET_COUNT),
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int unsigned SP_W   = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1,
  localparam int unsigned SC_W   = $clog2(MAX_PATHS + 1),
  localparam int unsigned SLOTS  = BUCKET_COUNT * WAYS,
  localparam int unsigned SLOT_W = $clog2(SLOTS),
  localparam int unsigned PA_W   = $clog2(SLOTS * MAX_PATHS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire logic [1:0]        cmd_mode,
  input  wire logic [ADDR_W-1:0] cmd_addr,
  input  wire logic [BKT_W-1:0]  cmd_bucket,
  input  wire logic [SC_W-1:0]   cmd_count,
  input  wire logic              cmd_over,
  output logic [SP_W-1:0]        sp_raddr,
  input  wire logic [PATH_W-1:0] sp_rdata,
  output logic                   stage_done,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [PATH_W-1:0]      out_path_out,
  output logic [IDX_W-1:0]       out_path_index,
  output logic [CNT_W-1:0]       out_path_count,
  output logic                   out_last_result
);
  hpt_bk_state_t st_r, st_nxt;

  // valid bits live in a RAM with a sweep clear (one slot per cycle)
  logic              vw_we;
  logic [SLOT_W-1:0] vw_addr, vr_addr;
  logic              vw_data, vr_data;
  logic              kw_we;
  logic [SLOT_W-1:0] k_raddr;
  logic [ADDR_W+SC_W-1:0] kw_data, kr_data;
  logic              pw_we;
  logic [PA_W-1:0]   pw_addr, pr_addr;
  logic [PATH_W-1:0] pr_data;

  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [WAY_W:0]    way_r, way_nxt;     // probe issue counter
  logic [WAY_W:0]    chk_r, chk_nxt;     // probe result counter
  logic              hit_r, hit_nxt;
  logic [WAY_W-1:0]  hway_r, hway_nxt;
  logic              free_r, free_nxt;
  logic [WAY_W-1:0]  fway_r, fway_nxt;
  logic [SC_W-1:0]   hcnt_r, hcnt_nxt;
  logic [SC_W-1:0]   pi_r, pi_nxt;       // path index
  logic [SC_W-1:0]   ecnt;
  logic [SLOT_W-1:0] slot_sel;
  logic [WAY_W-1:0]  cur_way;

  logic              ov_r, ov_nxt;
  logic [1:0]        os_r, os_nxt;
  logic [PATH_W-1:0] op_r, op_nxt;
  logic [IDX_W-1:0]  oi_r, oi_nxt;
  logic [CNT_W-1:0]  oc_r, oc_nxt;
  logic              ol_r, ol_nxt;
  logic              out_free;

  hpt_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_valid (
    .clk, .we(vw_we), .waddr(vw_addr), .wdata(vw_data), .raddr(vr_addr), .rdata(vr_data));
  hpt_ram #(.WIDTH(ADDR_W + SC_W), .DEPTH(SLOTS)) u_key (
    .clk, .we(kw_we), .waddr(vw_addr), .wdata(kw_data), .raddr(k_raddr), .rdata(kr_data));
  hpt_ram #(.WIDTH(PATH_W), .DEPTH(SLOTS * MAX_PATHS)) u_paths (
    .clk, .we(pw_we), .waddr(pw_addr), .wdata(sp_rdata), .raddr(pr_addr), .rdata(pr_data));

  assign out_free = !ov_r || out_ready;
  assign cur_way  = chk_r[WAY_W-1:0];
  assign slot_sel = SLOT_W'(cmd_bucket * WAYS + (hit_r ? hway_r : fway_r));
  assign ecnt     = kr_data[SC_W-1:0];
  assign k_raddr  = vr_addr;
  assign sp_raddr = pi_r[SP_W-1:0];
  assign kw_data  = {cmd_addr, cmd_count};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_CLEAR;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    way_r <= way_nxt; chk_r <= chk_nxt; hit_r <= hit_nxt; hway_r <= hway_nxt;
    free_r <= free_nxt; fway_r <= fway_nxt; hcnt_r <= hcnt_nxt;
    pi_r <= pi_nxt;
    os_r <= os_nxt; op_r <= op_nxt; oi_r <= oi_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt;
  end

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r;
    way_nxt = way_r; chk_nxt = chk_r; hit_nxt = hit_r; hway_nxt = hway_r;
    free_nxt = free_r; fway_nxt = fway_r; hcnt_nxt = hcnt_r;
    pi_nxt = pi_r;
    ov_nxt = ov_r && !out_ready;
    os_nxt = os_r; op_nxt = op_r; oi_nxt = oi_r; oc_nxt = oc_r; ol_nxt = ol_r;
    cmd_ready = 1'b0; stage_done = 1'b0;
    vw_we = 1'b0; vw_addr = clr_r; vw_data = 1'b0;
    vr_addr = SLOT_W'(cmd_bucket * WAYS + way_r[WAY_W-1:0]);
    kw_we = 1'b0; pw_we = 1'b0;
    if (MAX_PATHS > 1) begin
      pw_addr = PA_W'(slot_sel * MAX_PATHS + pi_r);
      pr_addr = PA_W'(slot_sel * MAX_PATHS + pi_r);
    end else begin
      pw_addr = PA_W'(slot_sel);
      pr_addr = PA_W'(slot_sel);
    end
    case (st_r)
      BK_CLEAR: begin
        vw_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLOT_W'(SLOTS - 1)) begin
          clr_nxt = '0;
          st_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (cmd_valid) begin
          way_nxt = '0; chk_nxt = '0; hit_nxt = 1'b0; free_nxt = 1'b0;
          pi_nxt = '0;
          case (cmd_mode)
            MODE_CLEAR: begin
              if (out_free) begin
                st_nxt = BK_CLEAR; cmd_ready = 1'b1;
                ov_nxt = 1'b1; os_nxt = ST_OK; op_nxt = '0; oi_nxt = '0;
                oc_nxt = '0; ol_nxt = 1'b1;
              end
            end
            MODE_INSERT: begin
              if (cmd_over) begin
                if (out_free) begin
                  cmd_ready = 1'b1; stage_done = 1'b1;
                  ov_nxt = 1'b1; os_nxt = ST_TOOMANY; op_nxt = '0; oi_nxt = '0;
                  oc_nxt = '0; ol_nxt = 1'b1;
                end
              end else begin
                st_nxt = BK_PROBE;
              end
            end
            default: st_nxt = BK_PROBE;
          endcase
        end
      end
      BK_PROBE: begin
        // one way read issued per cycle; each result checked in the cycle after its read
        if (way_r != (WAY_W+1)'(WAYS)) begin
          way_nxt = way_r + 1'b1;
        end
        if (way_r != '0) begin
          chk_nxt = chk_r + 1'b1;
          if (vr_data && kr_data[ADDR_W+SC_W-1:SC_W] == cmd_addr && !hit_r) begin
            hit_nxt = 1'b1; hway_nxt = cur_way; hcnt_nxt = ecnt;
          end
          if (!vr_data && !free_r) begin
            free_nxt = 1'b1; fway_nxt = cur_way;
          end
          if (chk_r == (WAY_W+1)'(WAYS - 1)) begin
            st_nxt = BK_DECIDE;
          end
        end
      end
      BK_DECIDE: begin
        if (cmd_mode == MODE_SEARCH) begin
          if (!hit_r || hcnt_r == '0) begin
            if (out_free) begin
              cmd_ready = 1'b1; st_nxt = BK_IDLE;
              if (!hit_r) begin
                ov_nxt = 1'b1; os_nxt = ST_NOTFOUND; op_nxt = '0; oi_nxt = '0;
                oc_nxt = '0; ol_nxt = 1'b1;
              end
            end
          end else begin
            st_nxt = BK_SEARCH;
          end
        end else if (!hit_r && !free_r) begin
          if (out_free) begin
            cmd_ready = 1'b1; stage_done = 1'b1; st_nxt = BK_IDLE;
            ov_nxt = 1'b1; os_nxt = ST_FULL; op_nxt = '0; oi_nxt = '0;
            oc_nxt = '0; ol_nxt = 1'b1;
          end
        end else begin
          st_nxt = BK_COPY;
          vw_we = 1'b1; vw_addr = slot_sel; vw_data = 1'b1; kw_we = 1'b1;
        end
      end
      BK_COPY: begin
        if (pi_r != cmd_count) begin
          pw_we = 1'b1;
          pi_nxt = pi_r + 1'b1;
        end else if (out_free) begin
          cmd_ready = 1'b1; stage_done = 1'b1; st_nxt = BK_IDLE;
          ov_nxt = 1'b1; os_nxt = ST_OK; op_nxt = '0; oi_nxt = '0;
          oc_nxt = '0; ol_nxt = 1'b1;
        end
      end
      BK_SEARCH: begin
        // issue read of path pi_r; data arrives next cycle in BK_EMIT
        st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1; os_nxt = ST_OK; op_nxt = pr_data;
          oi_nxt = IDX_W'(pi_r); oc_nxt = CNT_W'(hcnt_r);
          ol_nxt = (pi_r + 1'b1 == hcnt_r);
          pi_nxt = pi_r + 1'b1;
          if (pi_r + 1'b1 == hcnt_r) begin
            cmd_ready = 1'b1; st_nxt = BK_IDLE;
          end else begin
            st_nxt = BK_SEARCH;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_path_out    = op_r;
  assign out_path_index  = oi_r;
  assign out_path_count  = oc_r;
  assign out_last_result = ol_r;
endmodule
`default_nettype wire

// File: hw/rtl/hashed_path_table.sv
`default_nettype none
// Hashed path table. A 32-bit destination key folds to a bucket (bytes
// high first, sum*10+byte, mod BUCKET_COUNT); each bucket holds WAYS
// entries of up to MAX_PATHS path ids. mode 0 searches and streams every
// stored path (last_result on the final one) or one not-found result;
// mode 1 stages one path id per transaction and the transaction with
// path_last commits the set; mode 2 empties the table; mode 3 is dropped.
// The front hashes in three fold steps, a wait for the reciprocal quotient
// and a queue step, and queues up to two commands; a staged insert (not
// last) needs no hash. The back end probes one way per cycle up to the
// decision, then a search reads each returned path in BK_SEARCH and emits
// it in BK_EMIT, and a commit copies every staged path before its result.
// Clear, and reset, run a sweep of the valid RAM, one slot per cycle;
// items are still taken into the queue meanwhile.
module hashed_path_table
  import hpt_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = 256,
  parameter int unsigned WAYS         = 4,
  parameter int unsigned MAX_PATHS    = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_mode,
  input  wire logic [ADDR_W-1:0] in_dest_addr,
  input  wire logic [PATH_W-1:0] in_path_id,
  input  wire logic              in_path_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             out_status,
  output logic [PATH_W-1:0]      out_path_out,
  output logic [IDX_W-1:0]       out_path_index,
  output logic [CNT_W-1:0]       out_path_count,
  output logic                   out_last_result
);
  localparam int unsigned BKT_W = $clog2(BUCKET_COUNT);
  localparam int unsigned SP_W  = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int unsigned SC_W  = $clog2(MAX_PATHS + 1);

  logic              cmd_valid, cmd_ready, cmd_over, stage_done;
  logic [1:0]        cmd_mode;
  logic [ADDR_W-1:0] cmd_addr;
  logic [BKT_W-1:0]  cmd_bucket;
  logic [SC_W-1:0]   cmd_count;
  logic [SP_W-1:0]   sp_raddr;
  logic [PATH_W-1:0] sp_rdata;

  hpt_front #(.BUCKET_COUNT(BUCKET_COUNT), .MAX_PATHS(MAX_PATHS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_dest_addr, .in_path_id,
    .in_path_last, .cmd_valid, .cmd_ready, .cmd_mode, .cmd_addr, .cmd_bucket,
    .cmd_count, .cmd_over, .sp_raddr, .sp_rdata, .stage_done);

  hpt_back #(.BUCKET_COUNT(BUCKET_COUNT), .WAYS(WAYS), .MAX_PATHS(MAX_PATHS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_mode, .cmd_addr, .cmd_bucket,
    .cmd_count, .cmd_over, .sp_raddr, .sp_rdata, .stage_done, .out_valid,
    .out_ready, .out_status, .out_path_out, .out_path_index, .out_path_count,
    .out_last_result);
endmodule
`default_nettype wire

// File: hw/rtl/hpt_checker.sv
`default_nettype none
`include "hashed_path_table_assert.svh"
module hpt_checker
  import hpt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_path_out,
  input wire logic [2:0]  out_path_index,
  input wire logic [3:0]  out_path_count,
  input wire logic        out_last_result
);
  `HPT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_path_out), "result dropped while stalled")
  `HPT_ASSERT_IMP(a_err_last, clk, rst_n, out_valid && out_status != ST_OK, out_last_result && out_path_out == 32'd0, "error result not final")
  `HPT_ASSERT_IMP(a_idx_cnt, clk, rst_n, out_valid && out_path_count != 4'd0, {1'b0, out_path_index} < out_path_count, "index beyond count")
  `HPT_ASSERT_IMP(a_last_idx, clk, rst_n, out_valid && out_path_count != 4'd0 && out_last_result, {1'b0, out_path_index} + 4'd1 == out_path_count, "last mark misplaced")
endmodule

bind hashed_path_table hpt_checker u_hpt_checker (.*);
`default_nettype wire
